FILE: rtl/vrrf_pkg.sv
`default_nettype none
package vrrf_pkg;

  localparam int QUEUE_BYTES         = 1024;
  localparam int MAX_RECORD_BYTES    = 64;
  localparam int LENGTH_PREFIX_BYTES = 8;

  localparam int PTR_W  = $clog2(QUEUE_BYTES);
  localparam int FREE_W = $clog2(QUEUE_BYTES + 1);
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_OPEN    = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SEQ   = 2'd3;

  localparam logic [FREE_W-1:0] FREE_ALL   = FREE_W'(QUEUE_BYTES);
  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_RECORD_BYTES);
  localparam logic [FREE_W-1:0] PREFIX_LEN = FREE_W'(LENGTH_PREFIX_BYTES);

  // result fields decided by the controller; the byte comes from the ring
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              byte_valid;
    logic              last;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
  } res_t;

  typedef struct packed {
    res_t              res;
    logic [BYTE_W-1:0] out_byte;
  } entry_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W:0]   k);
    logic [PTR_W+1:0] sum;
    sum = {1'b0, p} + {1'b0, k};
    if (sum >= (PTR_W+2)'(QUEUE_BYTES)) begin
      sum = sum - (PTR_W+2)'(QUEUE_BYTES);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vrrf_ram.sv
`default_nettype none
module vrrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vrrf_outq.sv
`default_nettype none
module vrrf_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      issue,
  input  vrrf_pkg::res_t            issue_res,
  input  logic [vrrf_pkg::BYTE_W-1:0] rdata,
  output logic                      room,
  output logic                      m_valid,
  input  logic                      m_ready,
  output vrrf_pkg::entry_t          m_entry
);
  import vrrf_pkg::*;

  // one stage lines up with the ring read latency, then a two-entry buffer
  logic           stage_valid;
  res_t           stage_res;
  entry_t         q [2];
  logic           wr_idx;
  logic           rd_idx;
  logic [1:0]     count;
  logic           pop;
  logic [2:0]     occ_next;
  entry_t         push_entry;

  assign pop      = m_valid && m_ready;
  assign m_valid  = (count != 2'd0);
  assign m_entry  = q[rd_idx];
  assign occ_next = 3'(count) + 3'(stage_valid) - 3'(pop);
  assign room     = (occ_next < 3'd2);

  always_comb begin
    push_entry.res      = stage_res;
    push_entry.out_byte = stage_res.byte_valid ? rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      wr_idx      <= 1'b0;
      rd_idx      <= 1'b0;
      count       <= 2'd0;
    end else begin
      stage_valid <= issue;
      if (stage_valid) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      count <= 2'(3'(count) + 3'(stage_valid) - 3'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stage_res <= issue_res;
    end
    if (stage_valid) begin
      q[wr_idx] <= push_entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vrrf_ctrl.sv
`default_nettype none
module vrrf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vrrf_pkg::OP_W-1:0]   opcode,
  input  logic [vrrf_pkg::LEN_W-1:0]  length,
  input  logic [vrrf_pkg::BYTE_W-1:0] data_byte,
  input  logic                        room,
  output logic                        issue,
  output vrrf_pkg::res_t              issue_res,
  output logic                        ram_we,
  output logic [vrrf_pkg::PTR_W-1:0]  ram_waddr,
  output logic [vrrf_pkg::BYTE_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [vrrf_pkg::PTR_W-1:0]  ram_raddr,
  input  logic [vrrf_pkg::BYTE_W-1:0] ram_rdata
);
  import vrrf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PREFIX = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0]        state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [FREE_W-1:0] free, free_next;
  logic [LEN_W-1:0]  open_rem, open_rem_next;
  logic [LEN_W-1:0]  bufsize, bufsize_next;
  logic              consume, consume_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic [LEN_W-1:0]  remaining, remaining_next;

  logic              accept;
  logic [LEN_W-1:0]  stored;
  logic [LEN_W-1:0]  nbytes;
  logic [FREE_W:0]   need;
  logic [FREE_W:0]   freed;

  assign in_ready = (state == S_IDLE) && room;
  assign accept   = in_valid && in_ready;
  assign need     = (FREE_W+1)'(length) + {1'b0, PREFIX_LEN};
  assign stored   = (ram_rdata > BYTE_W'(MAX_RECORD_BYTES)) ? MAX_LEN
                                                            : ram_rdata[LEN_W-1:0];
  assign nbytes   = (bufsize < stored) ? bufsize : stored;
  assign freed    = {1'b0, free} + {1'b0, PREFIX_LEN} + (FREE_W+1)'(stored);

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    free_next      = free;
    open_rem_next  = open_rem;
    bufsize_next   = bufsize;
    consume_next   = consume;
    rp_next        = rp;
    remaining_next = remaining;
    issue          = 1'b0;
    issue_res      = '0;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = data_byte;
    ram_re         = 1'b0;
    ram_raddr      = rp;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          issue = 1'b1;
          issue_res.last = 1'b1;
          issue_res.status = STAT_OK;
          unique case (opcode)
            OP_OPEN: begin
              if (open_rem != '0) begin
                issue_res.status = STAT_SEQ;
              end else if (length > MAX_LEN || need > (FREE_W+1)'(free)) begin
                issue_res.status = STAT_FULL;
              end else begin
                // upper prefix bytes are not written and never read back
                ram_we        = 1'b1;
                ram_wdata     = BYTE_W'(length);
                tail_next     = ring_add(tail, (PTR_W+1)'(LENGTH_PREFIX_BYTES));
                free_next     = free - need[FREE_W-1:0];
                open_rem_next = length;
              end
            end
            OP_APPEND: begin
              if (open_rem == '0) begin
                issue_res.status = STAT_SEQ;
              end else begin
                ram_we        = 1'b1;
                tail_next     = ring_add(tail, (PTR_W+1)'(1));
                open_rem_next = open_rem - LEN_W'(1);
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (open_rem != '0) begin
                issue_res.status = STAT_SEQ;
              end else if (free >= FREE_ALL) begin
                issue_res.status = STAT_EMPTY;
              end else begin
                issue        = 1'b0;
                ram_re       = 1'b1;
                ram_raddr    = head;
                bufsize_next = length;
                consume_next = (opcode == OP_DEQUEUE);
                state_next   = S_PREFIX;
              end
            end
            OP_CLEAR: begin
              head_next     = tail;
              free_next     = FREE_ALL;
              open_rem_next = '0;
            end
            default: begin
              issue_res.status = STAT_SEQ;
            end
          endcase
          issue_res.free_bytes = free_next;
          issue_res.is_empty   = (free_next == FREE_ALL);
        end
      end
      S_PREFIX: begin
        rp_next        = ring_add(head, (PTR_W+1)'(LENGTH_PREFIX_BYTES));
        remaining_next = nbytes;
        if (consume) begin
          head_next = ring_add(head, (PTR_W+1)'(LENGTH_PREFIX_BYTES) + (PTR_W+1)'(stored));
          free_next = (freed > (FREE_W+1)'(FREE_ALL)) ? FREE_ALL : freed[FREE_W-1:0];
        end
        state_next = S_STREAM;
      end
      S_STREAM: begin
        issue_res.status     = STAT_OK;
        issue_res.free_bytes = free;
        issue_res.is_empty   = (free == FREE_ALL);
        if (room) begin
          issue = 1'b1;
          if (remaining == '0) begin
            issue_res.last = 1'b1;
            state_next     = S_IDLE;
          end else begin
            issue_res.byte_valid = 1'b1;
            issue_res.last       = (remaining == LEN_W'(1));
            ram_re               = 1'b1;
            rp_next              = ring_add(rp, (PTR_W+1)'(1));
            remaining_next       = remaining - LEN_W'(1);
            if (remaining == LEN_W'(1)) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      free     <= FREE_ALL;
      open_rem <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      free     <= free_next;
      open_rem <= open_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    bufsize   <= bufsize_next;
    consume   <= consume_next;
    rp        <= rp_next;
    remaining <= remaining_next;
  end

endmodule
`default_nettype wire

FILE: rtl/variable_record_ring_fifo.sv
`default_nettype none
// Byte ring of 1024 entries holding length-prefixed records (8-byte prefix,
// up to 64 payload bytes). Every item gives one or more result transfers
// on the m side. Open, append, clear and refused items are answered from
// the idle state; a dequeue or peek that reaches the ring reads the prefix,
// sizes the record, then reads the bytes one by one through the single
// ring read port, waiting while the output buffer has no room (one result
// without a byte when none). A two-entry output buffer lets the block
// take the next item while earlier results wait to be taken; s_tready drops
// while a read burst runs or the buffer is full.
module variable_record_ring_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // length[6:0], data_byte[14:7], zero pad
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[1:0], out_byte[9:2], free_bytes[20:10],
                                 // is_empty[21], zero pad
  output logic [0:0]  m_tuser,   // byte_valid[0]
  output logic        m_tlast
);
  import vrrf_pkg::*;

  logic              room;
  logic              issue;
  res_t              issue_res;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  entry_t            m_entry;

  vrrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (s_tuser),
    .length    (s_tdata[6:0]),
    .data_byte (s_tdata[14:7]),
    .room      (room),
    .issue     (issue),
    .issue_res (issue_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  vrrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vrrf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_res (issue_res),
    .rdata     (ram_rdata),
    .room      (room),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_entry   (m_entry)
  );

  assign m_tdata = {2'b00, m_entry.res.is_empty, m_entry.res.free_bytes,
                    m_entry.out_byte, m_entry.res.status};
  assign m_tuser = m_entry.res.byte_valid;
  assign m_tlast = m_entry.res.last;

endmodule
`default_nettype wire

FILE: rtl/vrrf_checker.sv
`default_nettype none
module vrrf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);
  import vrrf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result transfer changed");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[9:2] == '0 && m_tlast)
    else $error("result without byte is not a lone zero-byte transfer");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[1:0] == STAT_OK)
    else $error("byte transfer with non-ok status");

  a_empty_free: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[21] == (m_tdata[20:10] == FREE_ALL))
    else $error("empty flag disagrees with free count");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:10] <= FREE_ALL)
    else $error("free count above ring size");

endmodule

bind variable_record_ring_fifo vrrf_checker u_vrrf_checker (.*);
`default_nettype wire

FILE: verif/record_fifo_checker.sv
module record_fifo_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // length[6:0], data_byte[14:7], zero pad
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // status[1:0], out_byte[9:2], free_bytes[20:10],
                                 // is_empty[21], zero pad
  input  logic [0:0]  m_tuser,   // byte_valid[0]
  input  logic        m_tlast,
  output int          fails,
  output int          pending,
  output int          results
);
  import vrrf_pkg::*;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
  } beat_t;

  logic [BYTE_W-1:0] ring [QUEUE_BYTES];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  int                free_cnt;
  int                open_left;
  int                err_count;
  int                beat_count;
  beat_t             expected_beats[$];

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p, int k);
    return PTR_W'((int'(p) + k) % QUEUE_BYTES);
  endfunction

  function automatic void push_beat(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b,
                                    logic v, logic l);
    beat_t e;
    e.status     = st;
    e.out_byte   = b;
    e.byte_valid = v;
    e.last       = l;
    e.free_bytes = FREE_W'(free_cnt);
    e.is_empty   = (free_cnt == QUEUE_BYTES);
    expected_beats.push_back(e);
  endfunction

  // front record: decode prefix, optionally release it, then emit payload bytes
  function automatic void read_front_record(int unsigned bufsize, bit consume);
    logic [63:0]      prefix;
    logic [PTR_W-1:0] p;
    int unsigned      stored;
    int unsigned      n;
    int               i;
    prefix = '0;
    p = head;
    for (i = 0; i < LENGTH_PREFIX_BYTES; i++) begin
      prefix |= 64'(ring[p]) << (8 * i);
      p = ring_next(p, 1);
    end
    stored = (prefix > 64'(MAX_RECORD_BYTES)) ? MAX_RECORD_BYTES : int'(prefix);
    n = (bufsize < stored) ? bufsize : stored;
    if (consume) begin
      head = ring_next(head, LENGTH_PREFIX_BYTES + stored);
      free_cnt += LENGTH_PREFIX_BYTES + stored;
      if (free_cnt > QUEUE_BYTES) begin
        free_cnt = QUEUE_BYTES;
      end
    end
    if (n == 0) begin
      push_beat(STAT_OK, '0, 1'b0, 1'b1);
    end else begin
      for (i = 0; i < n; i++) begin
        push_beat(STAT_OK, ring[p], 1'b1, i == n - 1);
        p = ring_next(p, 1);
      end
    end
  endfunction

  function automatic void predict_op(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                     logic [BYTE_W-1:0] db);
    int i;
    case (op)
      OP_OPEN: begin
        if (open_left != 0) begin
          push_beat(STAT_SEQ, '0, 1'b0, 1'b1);
        end else if (len > MAX_LEN || int'(len) + LENGTH_PREFIX_BYTES > free_cnt) begin
          push_beat(STAT_FULL, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < LENGTH_PREFIX_BYTES; i++) begin
            ring[tail] = BYTE_W'(64'(len) >> (8 * i));
            tail = ring_next(tail, 1);
          end
          free_cnt -= LENGTH_PREFIX_BYTES + int'(len);
          open_left = len;
          push_beat(STAT_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_APPEND: begin
        if (open_left == 0) begin
          push_beat(STAT_SEQ, '0, 1'b0, 1'b1);
        end else begin
          ring[tail] = db;
          tail = ring_next(tail, 1);
          open_left--;
          push_beat(STAT_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (open_left != 0) begin
          push_beat(STAT_SEQ, '0, 1'b0, 1'b1);
        end else if (free_cnt >= QUEUE_BYTES) begin
          push_beat(STAT_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          read_front_record(len, op == OP_DEQUEUE);
        end
      end
      OP_CLEAR: begin
        head = tail;
        free_cnt = QUEUE_BYTES;
        open_left = 0;
        push_beat(STAT_OK, '0, 1'b0, 1'b1);
      end
      default: begin
        push_beat(STAT_SEQ, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      head = '0;
      tail = '0;
      free_cnt = QUEUE_BYTES;
      open_left = 0;
      expected_beats.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_op(s_tuser, s_tdata[6:0], s_tdata[14:7]);
      end
      if (m_tvalid && m_tready) begin
        beat_count++;
        if (expected_beats.size() == 0) begin
          $error("result transfer with nothing expected: status %0d out_byte %0d",
                 m_tdata[1:0], m_tdata[9:2]);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status", want.status, m_tdata[1:0]);
          check_field("out_byte", want.out_byte, m_tdata[9:2]);
          check_field("byte_valid", want.byte_valid, m_tuser[0]);
          check_field("last", want.last, m_tlast);
          check_field("free_bytes", want.free_bytes, m_tdata[20:10]);
          check_field("is_empty", want.is_empty, m_tdata[21]);
        end
      end
    end
    fails   <= err_count;
    pending <= expected_beats.size();
    results <= beat_count;
  end

endmodule

FILE: verif/variable_record_ring_fifo_tb.sv
module variable_record_ring_fifo_tb;
  import vrrf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int FILL_SLACK  = 40;
  localparam int HOLD_CYCLES = 300;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;   // length[6:0], data_byte[14:7], zero pad
  logic [2:0]  s_tuser  = '0;   // opcode[2:0]
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;         // status[1:0], out_byte[9:2], free_bytes[20:10],
                                // is_empty[21], zero pad
  logic [0:0]  m_tuser;         // byte_valid[0]
  logic        m_tlast;

  int fails;
  int pending;
  int results;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int used;

  always #2 clk = ~clk;

  variable_record_ring_fifo dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  record_fifo_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .fails    (fails),
    .pending  (pending),
    .results  (results)
  );

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(logic [OP_W-1:0] op, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] db);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, db, len};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [LEN_W-1:0] reader_len();
    return ($urandom_range(3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(MAX_RECORD_BYTES));
  endfunction

  // open + payload; now and then a stray op lands mid-record
  task automatic send_record(int len);
    int j;
    send(OP_OPEN, LEN_W'(len), BYTE_W'($urandom));
    for (j = 0; j < len; j++) begin
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(2))
          0:       send(OP_OPEN, LEN_W'($urandom), BYTE_W'($urandom));
          1:       send(OP_DEQUEUE, reader_len(), BYTE_W'($urandom));
          default: send(OP_PEEK, reader_len(), BYTE_W'($urandom));
        endcase
      end
      send(OP_APPEND, LEN_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  task automatic random_mix(int count);
    int done;
    int r;
    int len;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 50) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(MAX_RECORD_BYTES) : $urandom_range(6);
        send_record(len);
        done += len + 1;
      end else if (r < 72) begin
        send(OP_DEQUEUE, reader_len(), BYTE_W'($urandom));
        done++;
      end else if (r < 85) begin
        send(OP_PEEK, reader_len(), BYTE_W'($urandom));
        done++;
      end else begin
        case ($urandom_range(3))
          0:       send(OP_APPEND, LEN_W'($urandom), BYTE_W'($urandom));
          1:       send(OP_W'($urandom_range(5, 7)), LEN_W'($urandom), BYTE_W'($urandom));
          2:       send(OP_OPEN, LEN_W'($urandom_range(MAX_RECORD_BYTES + 1, 127)),
                        BYTE_W'($urandom));
          default: send(OP_CLEAR, LEN_W'($urandom), BYTE_W'($urandom));
        endcase
        done++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send(OP_DEQUEUE, 7'd64, 8'h00);
    send(OP_PEEK, 7'd1, 8'h00);
    send(OP_APPEND, 7'd0, 8'hFF);
    send(OP_OPEN, 7'd0, 8'h00);
    send(OP_PEEK, 7'd10, 8'h00);
    send(OP_DEQUEUE, 7'd0, 8'h00);
    send(OP_OPEN, 7'd65, 8'h00);
    send(OP_OPEN, 7'd127, 8'hFF);
    send(OP_OPEN, 7'd3, 8'h00);
    send(OP_OPEN, 7'd0, 8'h00);
    send(OP_DEQUEUE, 7'd3, 8'h00);
    send(OP_APPEND, 7'd0, 8'h00);
    send(OP_APPEND, 7'd127, 8'hFF);
    send(OP_PEEK, 7'd3, 8'h00);
    send(OP_APPEND, 7'd0, 8'hA5);
    send(OP_APPEND, 7'd0, 8'h5A);
    send(OP_PEEK, 7'd0, 8'h00);
    send(OP_PEEK, 7'd2, 8'h00);
    send(OP_DEQUEUE, 7'd127, 8'h00);
    send(OP_DEQUEUE, 7'd64, 8'h00);
    send(3'd5, 7'd0, 8'h00);
    send(3'd6, 7'd0, 8'h00);
    send(3'd7, 7'd0, 8'h00);
    send(OP_CLEAR, 7'd0, 8'h00);

    // fill the ring near capacity while the receiver holds off
    hold_left <= HOLD_CYCLES;
    used = 0;
    while (QUEUE_BYTES - used > FILL_SLACK) begin
      if ($urandom_range(7) == 0) begin
        send(OP_OPEN, 7'd1, BYTE_W'($urandom));
        send(OP_APPEND, LEN_W'($urandom), BYTE_W'($urandom));
        used += LENGTH_PREFIX_BYTES + 1;
      end else begin
        send(OP_OPEN, 7'd0, BYTE_W'($urandom));
        used += LENGTH_PREFIX_BYTES;
      end
    end
    // one byte more than fits
    send(OP_OPEN, LEN_W'(QUEUE_BYTES - used - LENGTH_PREFIX_BYTES + 1), 8'h00);
    send(OP_PEEK, 7'd64, 8'h00);
    send(OP_DEQUEUE, 7'd1, 8'h00);
    send(OP_CLEAR, 7'd0, 8'h00);

    // head now sits close to the top of the ring, so records wrap
    send_record(MAX_RECORD_BYTES);
    send(OP_PEEK, 7'd64, 8'h00);
    random_mix(10);
    idle_pct = 77;
    random_mix(10);
    idle_pct  = 0;
    stall_pct = 77;
    random_mix(10);
    idle_pct  = 7;
    stall_pct = 7;
    random_mix(10);
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items, checked %0d result transfers.", items_sent, results);
    $display("Run hit status codes, near-full ring with wrap, hold-off backpressure, idle mixes.");
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/vrrf_pkg.sv
rtl/vrrf_ram.sv
rtl/vrrf_outq.sv
rtl/vrrf_ctrl.sv
rtl/variable_record_ring_fifo.sv
rtl/vrrf_checker.sv
verif/record_fifo_checker.sv
verif/variable_record_ring_fifo_tb.sv
